>>> sv/multi_reader_ring_queue_core_defines.svh
// Assertion macros for the multi-reader ring queue.
// Used by the checker; expects clk_i and rst_ni in scope.
`ifndef MULTI_READER_RING_QUEUE_CORE_DEFINES_SVH
`define MULTI_READER_RING_QUEUE_CORE_DEFINES_SVH

// Checked outside reset only.
`define MRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define MRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/mrq_pkg.sv
// Shared types and codes for the multi-reader ring queue.
// No dependencies.
package mrq_pkg;

  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_REG = 2'd1;
  localparam logic [1:0] OP_DEQ = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOSLOT    = 3'd3;
  localparam logic [2:0] ST_BADREADER = 3'd4;

  localparam logic [3:0] MAX_WORD_BYTES = 4'd8;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] data;
    logic [7:0]  length;
    logic [3:0]  reader;
    logic [7:0]  buffer_size;
  } mrq_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_data;
    logic [3:0]  byte_count;
    logic [2:0]  assigned_reader;
  } mrq_rsp_t;

  // Pointer table commands, one per committed transaction.
  typedef struct packed {
    logic       do_enq;
    logic       do_reg;
    logic       do_deq;
    logic [3:0] reader;
  } mrq_tbl_cmd_t;

  typedef struct packed {
    logic full;
    logic sel_empty;
    logic no_slot;
  } mrq_tbl_sts_t;

endpackage

>>> sv/mrq_entry_ram.sv
// Entry store: simple dual-port synchronous RAM with registered read.
// No dependencies.
module mrq_entry_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/mrq_ptr_table.sv
// Write index, per-reader read index and unread count, slot allocation.
// Depends on mrq_pkg.
module mrq_ptr_table #(
  parameter int CAPACITY    = 16,
  parameter int MAX_READERS = 8,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int RW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1,
  localparam int SW = $clog2(MAX_READERS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mrq_pkg::mrq_tbl_cmd_t cmd_i,
  output mrq_pkg::mrq_tbl_sts_t sts_o,
  output logic [IW-1:0]         wr_idx_o,
  output logic [IW-1:0]         rd_idx_o,
  output logic [SW-1:0]         slot_o
);
  import mrq_pkg::*;

  logic [IW-1:0] wr_idx_q, wr_idx_d;
  logic [SW-1:0] next_slot_q, next_slot_d;
  logic [IW-1:0] rd_idx_q [MAX_READERS];
  logic [IW-1:0] rd_idx_d [MAX_READERS];
  logic [CW-1:0] cnt_q [MAX_READERS];
  logic [CW-1:0] cnt_d [MAX_READERS];
  logic [MAX_READERS-1:0] regd_q, regd_d;

  logic [RW-1:0] sel_idx;
  logic          sel_valid;
  logic [RW-1:0] new_idx;
  logic          full;

  assign sel_idx   = cmd_i.reader[RW-1:0];
  assign sel_valid = {1'b0, cmd_i.reader} < 5'(MAX_READERS);
  assign new_idx   = next_slot_q[RW-1:0];

  always_comb begin
    full = 1'b0;
    for (int i = 0; i < MAX_READERS; i++) begin
      full = full | (regd_q[i] && (cnt_q[i] >= CW'(CAPACITY)));
    end
  end

  assign sts_o.full      = full;
  assign sts_o.no_slot   = next_slot_q == SW'(MAX_READERS);
  assign sts_o.sel_empty = !sel_valid || !regd_q[sel_idx] || (cnt_q[sel_idx] == '0);
  assign rd_idx_o = sel_valid ? rd_idx_q[sel_idx] : '0;
  assign wr_idx_o = wr_idx_q;
  assign slot_o   = next_slot_q;

  always_comb begin
    wr_idx_d    = wr_idx_q;
    next_slot_d = next_slot_q;
    regd_d      = regd_q;
    rd_idx_d    = rd_idx_q;
    cnt_d       = cnt_q;
    if (cmd_i.do_enq) begin
      wr_idx_d = (wr_idx_q == IW'(CAPACITY - 1)) ? '0 : wr_idx_q + 1'b1;
      for (int i = 0; i < MAX_READERS; i++) begin
        if (regd_q[i]) begin
          cnt_d[i] = cnt_q[i] + 1'b1;
        end
      end
    end
    if (cmd_i.do_reg) begin
      regd_d[new_idx]   = 1'b1;
      cnt_d[new_idx]    = '0;
      rd_idx_d[new_idx] = wr_idx_q;
      next_slot_d       = next_slot_q + 1'b1;
    end
    if (cmd_i.do_deq) begin
      rd_idx_d[sel_idx] = (rd_idx_q[sel_idx] == IW'(CAPACITY - 1)) ? '0 :
                          rd_idx_q[sel_idx] + 1'b1;
      cnt_d[sel_idx]    = cnt_q[sel_idx] - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '0;
      next_slot_q <= '0;
      regd_q      <= '0;
      for (int i = 0; i < MAX_READERS; i++) begin
        rd_idx_q[i] <= '0;
        cnt_q[i]    <= '0;
      end
    end else begin
      wr_idx_q    <= wr_idx_d;
      next_slot_q <= next_slot_d;
      regd_q      <= regd_d;
      rd_idx_q    <= rd_idx_d;
      cnt_q       <= cnt_d;
    end
  end

endmodule

>>> sv/multi_reader_ring_queue_core.sv
// Top level of the multi-reader broadcast ring queue.
// Depends on mrq_pkg, mrq_entry_ram, mrq_ptr_table.
//
//   channel   handshake            payload
//   command   start / busy         req_i  (mrq_req_t)
//   result    done_o (strobe)      rsp_o  (mrq_rsp_t)
//
// Each transaction has an execute cycle that updates the
// pointer table and issues the entry RAM access, then a result cycle that
// shows the RAM read data. The next command is taken in the result cycle.
// busy is high during the execute cycle only. Reset clears all pointers
// and slots; the entry RAM is not cleared. Results cannot be stalled.
module multi_reader_ring_queue_core #(
  parameter int CAPACITY    = 16,
  parameter int MAX_READERS = 8,
  parameter int ENTRY_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mrq_pkg::mrq_req_t req_i,
  output logic              done_o,
  output mrq_pkg::mrq_rsp_t rsp_o
);
  import mrq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int SW = $clog2(MAX_READERS + 1);
  localparam int DW = 8 * ENTRY_BYTES;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  function automatic logic [3:0] clip_bytes(input logic [7:0] n);
    return (n >= 8'(ENTRY_BYTES)) ? 4'(ENTRY_BYTES) : n[3:0];
  endfunction

  function automatic logic [DW-1:0] byte_mask(input logic [3:0] n);
    logic [DW-1:0] m;
    for (int k = 0; k < ENTRY_BYTES; k++) begin
      m[8*k +: 8] = {8{4'(k) < n}};
    end
    return m;
  endfunction

  logic [1:0]    state_q, state_d;
  logic          accept;
  mrq_req_t      req_q;

  logic [2:0]    status_q, status_d;
  logic [3:0]    count_q, count_d;
  logic [2:0]    slot_q, slot_d;
  logic [DW-1:0] mask_q, mask_d;

  mrq_tbl_cmd_t  cmd;
  mrq_tbl_sts_t  sts;
  logic [IW-1:0] wr_idx, rd_idx;
  logic [SW-1:0] next_slot;
  logic [4:0]    slot_ext;
  logic          ram_we, ram_re;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic          in_exec;

  assign busy    = state_q == S_EXEC;
  assign accept  = start && !busy;
  assign in_exec = state_q == S_EXEC;
  assign slot_ext = 5'(next_slot);

  always_comb begin
    priority if (accept) begin
      state_d = S_EXEC;
    end else if (state_q == S_EXEC) begin
      state_d = S_RESP;
    end else begin
      state_d = S_IDLE;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.reader = req_q.reader;
    status_d   = ST_OK;
    count_d    = '0;
    slot_d     = '0;
    mask_d     = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    if (in_exec) begin
      unique case (req_q.operation)
        OP_ENQ: begin
          if (sts.full) begin
            status_d = ST_FULL;
          end else begin
            cmd.do_enq = 1'b1;
            ram_we     = 1'b1;
          end
        end
        OP_REG: begin
          if (sts.no_slot) begin
            status_d = ST_NOSLOT;
          end else begin
            cmd.do_reg = 1'b1;
            slot_d     = slot_ext[2:0];
          end
        end
        OP_DEQ: begin
          if ({1'b0, req_q.reader} >= 5'(MAX_READERS)) begin
            status_d = ST_BADREADER;
          end else if (sts.sel_empty) begin
            status_d = ST_EMPTY;
          end else begin
            cmd.do_deq = 1'b1;
            ram_re     = 1'b1;
            count_d    = clip_bytes(req_q.buffer_size);
            mask_d     = byte_mask(count_d);
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  assign ram_wdata = req_q.data[DW-1:0] & byte_mask(clip_bytes(req_q.length));

  mrq_ptr_table #(
    .CAPACITY    (CAPACITY),
    .MAX_READERS (MAX_READERS)
  ) u_ptr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .wr_idx_o (wr_idx),
    .rd_idx_o (rd_idx),
    .slot_o   (next_slot)
  );

  mrq_entry_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (in_exec) begin
      status_q <= status_d;
      count_q  <= count_d;
      slot_q   <= slot_d;
      mask_q   <= mask_d;
    end
  end

  assign done_o                = state_q == S_RESP;
  assign rsp_o.status          = status_q;
  assign rsp_o.read_data       = 64'(ram_rdata & mask_q);
  assign rsp_o.byte_count      = count_q;
  assign rsp_o.assigned_reader = slot_q;

endmodule

>>> sv/mrq_checker.sv
// Port-level checks for multi_reader_ring_queue_core, bound to the top.
// Depends on mrq_pkg and multi_reader_ring_queue_core_defines.svh.
`include "multi_reader_ring_queue_core_defines.svh"

module mrq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input mrq_pkg::mrq_rsp_t rsp_o
);
  import mrq_pkg::*;

  `MRQ_ASSERT(a_accept_to_result, (start && !busy) |=> (busy && !done_o) ##1 (done_o && !busy), "transaction did not complete in two cycles")
  `MRQ_ASSERT(a_busy_single, busy |=> !busy, "busy held longer than one cycle")
  `MRQ_ASSERT(a_done_after_busy, done_o |-> $past(busy), "result without a preceding execute cycle")
  `MRQ_ASSERT(a_fail_no_data, (done_o && rsp_o.status != ST_OK) |-> (rsp_o.byte_count == 4'd0 && rsp_o.read_data == 64'd0 && rsp_o.byte_count <= MAX_WORD_BYTES), "failed transaction carries data")
  `MRQ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> (!busy && !done_o), "activity during reset")

endmodule

bind multi_reader_ring_queue_core mrq_checker u_mrq_checker (.*);

>>> test/multi_reader_ring_queue_core_tb.sv
// Testbench for multi_reader_ring_queue_core: directed table, then random traffic.
// Results are checked against an in-bench ring queue predictor, or against fixed expected values for directed rows.
// Depends on mrq_pkg and the core RTL.
`timescale 1ns / 1ps

module multi_reader_ring_queue_core_tb;
  import mrq_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int MAX_READERS = 8;
  localparam int ENTRY_BYTES = 8;

  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_EVERY  = 250;
  localparam int STALL_LIMIT  = 200;
  localparam int TAIL_CYCLES  = 8;
  localparam int SCRIPT_ROWS  = 25;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  mrq_req_t  req_i;
  logic      done_o;
  mrq_rsp_t  rsp_o;

  typedef struct {
    mrq_req_t req;
    int       reps;
    bit       fixed;
    mrq_rsp_t want;
  } script_row_t;

  script_row_t script [SCRIPT_ROWS];

  // predictor state
  logic [63:0] ring_word [CAPACITY];
  logic [63:0] head_pos = '0;
  logic [63:0] tail_pos [MAX_READERS];
  bit          attached [MAX_READERS];
  logic [3:0]  slots_given = '0;

  mrq_rsp_t awaited_rsp [$];
  int       errors_seen = 0;
  int       items_sent = 0;
  int       idle_cycles;

  multi_reader_ring_queue_core #(
    .CAPACITY    (CAPACITY),
    .MAX_READERS (MAX_READERS),
    .ENTRY_BYTES (ENTRY_BYTES)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic mrq_req_t cmd(input logic [1:0] op, input logic [63:0] data,
                                   input logic [7:0] len, input logic [3:0] rdr,
                                   input logic [7:0] bsz);
    mrq_req_t c;
    c.operation   = op;
    c.data        = data;
    c.length      = len;
    c.reader      = rdr;
    c.buffer_size = bsz;
    return c;
  endfunction

  function automatic mrq_rsp_t res(input logic [2:0] st, input logic [63:0] data,
                                   input logic [3:0] cnt, input logic [2:0] slot);
    mrq_rsp_t r;
    r.status          = st;
    r.read_data       = data;
    r.byte_count      = cnt;
    r.assigned_reader = slot;
    return r;
  endfunction

  function automatic int unsigned clip_bytes(input logic [7:0] n);
    return (n > ENTRY_BYTES) ? ENTRY_BYTES : n;
  endfunction

  function automatic logic [63:0] byte_mask(input int unsigned n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic mrq_rsp_t ring_queue_step(input mrq_req_t c);
    mrq_rsp_t    r;
    logic [63:0] least;
    int unsigned cnt;
    r = '0;
    r.status = ST_OK;
    case (c.operation)
      OP_ENQ: begin
        least = head_pos;
        for (int i = 0; i < MAX_READERS; i++) begin
          if (attached[i] && tail_pos[i] < least) least = tail_pos[i];
        end
        if ((head_pos - least) >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          ring_word[head_pos % CAPACITY] = c.data & byte_mask(clip_bytes(c.length));
          head_pos++;
        end
      end
      OP_REG: begin
        if (slots_given >= MAX_READERS) begin
          r.status = ST_NOSLOT;
        end else begin
          r.assigned_reader     = slots_given[2:0];
          tail_pos[slots_given] = head_pos;
          attached[slots_given] = 1'b1;
          slots_given++;
        end
      end
      OP_DEQ: begin
        if (c.reader >= MAX_READERS) begin
          r.status = ST_BADREADER;
        end else if (!attached[c.reader] || tail_pos[c.reader] == head_pos) begin
          r.status = ST_EMPTY;
        end else begin
          cnt               = clip_bytes(c.buffer_size);
          r.read_data       = ring_word[tail_pos[c.reader] % CAPACITY] & byte_mask(cnt);
          r.byte_count      = cnt[3:0];
          tail_pos[c.reader]++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly traffic that keeps the queue moving; the laggard reader gets many dequeues.
  function automatic mrq_req_t random_cmd();
    mrq_req_t    c;
    int unsigned pick;
    int unsigned lag;
    logic [63:0] most;
    c.data        = {$urandom(), $urandom()};
    c.length      = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 9))
                                               : 8'($urandom_range(0, 255));
    c.buffer_size = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 9))
                                               : 8'($urandom_range(0, 255));
    c.reader      = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      c.operation = OP_ENQ;
    end else if (pick < 92) begin
      c.operation = OP_DEQ;
      if (pick < 67) begin
        lag  = 0;
        most = '0;
        for (int i = 0; i < MAX_READERS; i++) begin
          if (attached[i] && (head_pos - tail_pos[i]) >= most) begin
            most = head_pos - tail_pos[i];
            lag  = i;
          end
        end
        c.reader = 4'(lag);
      end else if (pick < 87) begin
        c.reader = 4'($urandom_range(0, MAX_READERS - 1));
      end
    end else if (pick < 96) begin
      c.operation = OP_REG;
    end else begin
      c.operation = OP_NONE;
    end
    return c;
  endfunction

  task automatic issue(input mrq_req_t c, input bit fixed, input mrq_rsp_t want);
    mrq_rsp_t e;
    int       gap;
    gap = (((items_sent / 100) % 3) == 0) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= c;
    do @(posedge clk_i); while (busy);
    e = ring_queue_step(c);
    awaited_rsp.push_back(fixed ? want : e);
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (awaited_rsp.size() != 0);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    mrq_rsp_t e;
    if (rst_ni && done_o) begin
      if (awaited_rsp.size() == 0) begin
        $error("unexpected result transaction, status %0d", rsp_o.status);
        errors_seen++;
      end else begin
        e = awaited_rsp.pop_front();
        if (rsp_o.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp_o.status);
          errors_seen++;
        end
        if (rsp_o.read_data !== e.read_data) begin
          $error("read_data: expected %h, got %h", e.read_data, rsp_o.read_data);
          errors_seen++;
        end
        if (rsp_o.byte_count !== e.byte_count) begin
          $error("byte_count: expected %0d, got %0d", e.byte_count, rsp_o.byte_count);
          errors_seen++;
        end
        if (rsp_o.assigned_reader !== e.assigned_reader) begin
          $error("assigned_reader: expected %0d, got %0d", e.assigned_reader,
                 rsp_o.assigned_reader);
          errors_seen++;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    mrq_req_t c;
    for (int i = 0; i < CAPACITY; i++) ring_word[i] = '0;
    for (int i = 0; i < MAX_READERS; i++) begin
      tail_pos[i] = '0;
      attached[i] = 1'b0;
    end
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;

    script[0]  = '{cmd(OP_DEQ, '0, 8'd0, 4'd0, 8'd8), 1, 1'b1,
                   res(ST_EMPTY, '0, 4'd0, 3'd0)};
    script[1]  = '{cmd(OP_DEQ, '0, 8'd0, 4'd15, 8'd8), 1, 1'b1,
                   res(ST_BADREADER, '0, 4'd0, 3'd0)};
    script[2]  = '{cmd(OP_NONE, '1, 8'hff, 4'd15, 8'hff), 1, 1'b1,
                   res(ST_OK, '0, 4'd0, 3'd0)};
    // no reader yet: never full
    script[3]  = '{cmd(OP_ENQ, 64'h0123_4567_89ab_cdef, 8'd8, 4'd0, 8'd0), 17, 1'b0, '0};
    script[4]  = '{cmd(OP_REG, '0, 8'd0, 4'd0, 8'd0), 1, 1'b1,
                   res(ST_OK, '0, 4'd0, 3'd0)};
    script[5]  = '{cmd(OP_ENQ, '1, 8'hff, 4'd0, 8'd0), 1, 1'b1,
                   res(ST_OK, '0, 4'd0, 3'd0)};
    script[6]  = '{cmd(OP_DEQ, '0, 8'd0, 4'd0, 8'd0), 1, 1'b1,
                   res(ST_OK, '0, 4'd0, 3'd0)};
    script[7]  = '{cmd(OP_ENQ, '1, 8'd3, 4'd0, 8'd0), 1, 1'b1,
                   res(ST_OK, '0, 4'd0, 3'd0)};
    script[8]  = '{cmd(OP_DEQ, '0, 8'd0, 4'd0, 8'hff), 1, 1'b1,
                   res(ST_OK, 64'h00ff_ffff, 4'd8, 3'd0)};
    script[9]  = '{cmd(OP_DEQ, '0, 8'd0, 4'd0, 8'd8), 1, 1'b1,
                   res(ST_EMPTY, '0, 4'd0, 3'd0)};
    script[10] = '{cmd(OP_ENQ, 64'hfedc_ba98_7654_3210, 8'd0, 4'd0, 8'd0), 1, 1'b1,
                   res(ST_OK, '0, 4'd0, 3'd0)};
    script[11] = '{cmd(OP_DEQ, '0, 8'd0, 4'd0, 8'd5), 1, 1'b1,
                   res(ST_OK, '0, 4'd5, 3'd0)};
    script[12] = '{cmd(OP_ENQ, 64'h8877_6655_4433_2211, 8'd6, 4'd0, 8'd0), 1, 1'b0, '0};
    script[13] = '{cmd(OP_DEQ, '0, 8'd0, 4'd0, 8'd7), 1, 1'b0, '0};
    script[14] = '{cmd(OP_REG, '0, 8'd0, 4'd0, 8'd0), 1, 1'b1,
                   res(ST_OK, '0, 4'd0, 3'd1)};
    script[15] = '{cmd(OP_ENQ, 64'h5a5a_c3c3_0f0f_9696, 8'd8, 4'd0, 8'd0), 16, 1'b0, '0};
    script[16] = '{cmd(OP_ENQ, '1, 8'd8, 4'd0, 8'd0), 1, 1'b1,
                   res(ST_FULL, '0, 4'd0, 3'd0)};
    script[17] = '{cmd(OP_DEQ, '0, 8'd0, 4'd0, 8'd8), 1, 1'b0, '0};
    script[18] = '{cmd(OP_ENQ, '1, 8'd8, 4'd0, 8'd0), 1, 1'b1,
                   res(ST_FULL, '0, 4'd0, 3'd0)};
    script[19] = '{cmd(OP_DEQ, '0, 8'd0, 4'd1, 8'd8), 1, 1'b0, '0};
    script[20] = '{cmd(OP_ENQ, 64'h1122_3344_5566_7788, 8'd4, 4'd0, 8'd0), 1, 1'b1,
                   res(ST_OK, '0, 4'd0, 3'd0)};
    script[21] = '{cmd(OP_DEQ, '0, 8'd0, 4'd3, 8'd8), 1, 1'b1,
                   res(ST_EMPTY, '0, 4'd0, 3'd0)};
    script[22] = '{cmd(OP_REG, '0, 8'd0, 4'd0, 8'd0), 6, 1'b0, '0};
    script[23] = '{cmd(OP_REG, '0, 8'd0, 4'd0, 8'd0), 1, 1'b1,
                   res(ST_NOSLOT, '0, 4'd0, 3'd0)};
    script[24] = '{cmd(OP_DEQ, '0, 8'd0, 4'd8, 8'd8), 1, 1'b1,
                   res(ST_BADREADER, '0, 4'd0, 3'd0)};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[r]) begin
      for (int k = 0; k < script[r].reps; k++) begin
        issue(script[r].req, script[r].fixed, script[r].want);
      end
    end
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n > 0 && (n % DRAIN_EVERY) == 0) drain_results();
      c = random_cmd();
      issue(c, 1'b0, '0);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (errors_seen == 0 && awaited_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
